@@ rtl/core/ir_range_moving_average_defines.svh @@
// Assertion macros shared by the IR range moving average RTL.
`ifndef IR_RANGE_MOVING_AVERAGE_DEFINES_SVH
`define IR_RANGE_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define IRMA_ASSERT_IMP(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("irma: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define IRMA_ASSERT_NXT(name, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("irma: next-cycle check failed");
`else
`define IRMA_ASSERT_IMP(name, a, b)
`define IRMA_ASSERT_NXT(name, a, b)
`endif

`endif

@@ rtl/core/irma_pkg.sv @@
// Types and constants shared by the IR range moving average modules.
package irma_pkg;

  localparam int SMP_W      = 10;
  localparam int MEAN_W     = 10;
  localparam int NUM_W      = 16;
  localparam int DIST_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int QDVD_W     = NUM_W + FRAC_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DIST_NUM    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFS = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [SMP_W-1:0] LOW_LIMIT_RST   = SMP_W'(100);
  localparam logic [SMP_W-1:0] HIGH_LIMIT_RST  = SMP_W'(700);
  localparam logic [NUM_W-1:0] DIST_NUM_RST    = NUM_W'(2076);
  localparam logic [SMP_W-1:0] SENSOR_OFFS_RST = SMP_W'(11);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic [SMP_W-1:0] low_limit;
    logic [SMP_W-1:0] high_limit;
    logic [NUM_W-1:0] distance_numerator;
    logic [SMP_W-1:0] sensor_offset;
  } cfg_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] divisor;
  } fifo_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

endpackage

@@ rtl/core/irma_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module irma_div
  import irma_pkg::*;
#(
  parameter int DVD_W = 24,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Form the trial remainder from the next dividend bit
  always_comb begin
    trial = {rem, quotient[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Control: load on start, count down the steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the quotient in, keep the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DVS_W-1:0];
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

@@ rtl/core/irma_front.sv @@
// Front end: takes samples, keeps the window and sum, computes and screens the mean.
module irma_front
  import irma_pkg::*;
#(
  parameter int WINDOW_LEN = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [SMP_W-1:0] sample,
  input  fifo_status_t fifo_stat,
  output logic         push,
  output fifo_entry_t  entry
);

  localparam int SUM_W  = $clog2(WINDOW_LEN * ((1 << SMP_W) - 1) + 1);
  // Reciprocal of the window length, exact floor for every SUM_W-bit sum
  localparam int RCP_SH = SUM_W + $clog2(WINDOW_LEN);
  localparam int RCP_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((1 << RCP_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  front_state_t      state;
  front_state_t      state_next;
  logic [SMP_W-1:0]  win [WINDOW_LEN];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic              accept;
  logic [PROD_W-1:0] prod;
  logic [MEAN_W-1:0] mean;
  logic              pass;

  assign accept   = in_valid && in_ready;
  assign sum_next = sum - SUM_W'(win[0]) + SUM_W'(sample);
  // Divide the window sum by the window length
  assign prod     = PROD_W'(sum) * PROD_W'(RCP_MUL);
  assign mean     = prod[RCP_SH +: MEAN_W];
  assign pass     = (mean >= cfg.low_limit) && (mean <= cfg.high_limit)
                    && (mean > cfg.sensor_offset);

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    case (state)
      FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = FR_DIV;
        end
      end
      FR_DIV: begin
        state_next = pass ? FR_PUSH : FR_IDLE;
      end
      FR_PUSH: begin
        if (!fifo_stat.full) begin
          push       = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  // Advance the window and the running sum on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= SMP_W'(1);
      end
      sum <= SUM_W'(WINDOW_LEN);
    end else if (accept) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[WINDOW_LEN - 1] <= sample;
      sum <= sum_next;
    end
  end

  // Capture the screened mean and its divisor
  always_ff @(posedge clk) begin
    if (state == FR_DIV) begin
      entry.mean    <= mean;
      entry.divisor <= mean - cfg.sensor_offset;
    end
  end

endmodule

@@ rtl/core/irma_fifo.sv @@
// Two-entry queue between the front and back ends.
module irma_fifo
  import irma_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  fifo_entry_t  wr_entry,
  input  logic         pop,
  output fifo_entry_t  rd_entry,
  output fifo_status_t stat
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fifo_entry_t      mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_entry   = mem[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

@@ rtl/core/irma_back.sv @@
// Back end: divides the numerator by the offset mean and drives the result word.
module irma_back
  import irma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  fifo_entry_t       rd_entry,
  input  fifo_status_t      fifo_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MEAN_W-1:0] mean_value,
  output logic [DIST_W-1:0] distance_q8
);

  back_state_t       state;
  back_state_t       state_next;
  logic              div_done;
  logic [QDVD_W-1:0] div_quo;
  logic [QDVD_W-1:0] dividend;
  logic [MEAN_W-1:0] mean_hold;
  logic              out_free;
  logic              load;
  logic [DIST_W-1:0] dist_sat;

  assign dividend = {cfg.distance_numerator, {FRAC_W{1'b0}}};
  assign out_free = !out_valid || out_ready;
  assign dist_sat = (div_quo[QDVD_W-1:DIST_W] != '0) ? DIST_MAX : div_quo[DIST_W-1:0];

  // Divide numerator * 256 by (mean - offset)
  irma_div #(
    .DVD_W (QDVD_W),
    .DVS_W (MEAN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (pop),
    .dividend (dividend),
    .divisor  (rd_entry.divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and output load
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Latch the mean while its distance is computed
  always_ff @(posedge clk) begin
    if (pop) begin
      mean_hold <= rd_entry.mean;
    end
  end

  // Output register: load a new word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_value  <= mean_hold;
      distance_q8 <= dist_sat;
    end
  end

endmodule

@@ rtl/core/ir_range_moving_average.sv @@
// Top level of the IR range moving average: registers, front end, queue, back end.
//
// Input channel: in_valid/in_ready with one 10-bit raw sample per word. Each
// sample enters a window of the last WINDOW_LEN samples and the floor of the
// window mean is formed. A mean outside [low_limit, high_limit] or not above
// sensor_offset gives no word; otherwise one output word carries mean_value
// and distance_q8 = numerator*256/(mean - offset) in Q8.8, saturated at 65535.
// Configuration: cfg_we/cfg_index/cfg_data, one register per write, indexes
// above 3 ignored; write only while the block is idle.
// Timing: the front end takes a new sample only after the last one is
// screened in FR_DIV and, if it passes, pushed in FR_PUSH; its mean comes from
// a constant reciprocal multiply. The back end pops one entry at a time and
// holds it until its 24-step distance divider is done and the word is loaded.
// A two-word queue lets the front end keep taking samples while the back end
// works or the receiver stalls; a stalled output word is held in its register
// until out_ready.
// Reset: window entries set to 1, sum to WINDOW_LEN, registers to defaults.
module ir_range_moving_average
  import irma_pkg::*;
#(
  parameter int WINDOW_LEN = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SMP_W-1:0]      sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MEAN_W-1:0]     mean_value,
  output logic [DIST_W-1:0]     distance_q8
);

`include "ir_range_moving_average_defines.svh"

  cfg_t         cfg;
  fifo_entry_t  wr_entry;
  fifo_entry_t  rd_entry;
  fifo_status_t fifo_stat;
  logic         fifo_push;
  logic         fifo_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit          <= LOW_LIMIT_RST;
      cfg.high_limit         <= HIGH_LIMIT_RST;
      cfg.distance_numerator <= DIST_NUM_RST;
      cfg.sensor_offset      <= SENSOR_OFFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:   cfg.low_limit          <= cfg_data[SMP_W-1:0];
        REG_HIGH_LIMIT:  cfg.high_limit         <= cfg_data[SMP_W-1:0];
        REG_DIST_NUM:    cfg.distance_numerator <= cfg_data[NUM_W-1:0];
        REG_SENSOR_OFFS: cfg.sensor_offset      <= cfg_data[SMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irma_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .fifo_stat (fifo_stat),
    .push      (fifo_push),
    .entry     (wr_entry)
  );

  irma_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fifo_push),
    .wr_entry (wr_entry),
    .pop      (fifo_pop),
    .rd_entry (rd_entry),
    .stat     (fifo_stat)
  );

  irma_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rd_entry    (rd_entry),
    .fifo_stat   (fifo_stat),
    .pop         (fifo_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mean_value  (mean_value),
    .distance_q8 (distance_q8)
  );

  // Queue never overflows or underflows; front takes one sample at a time
  `IRMA_ASSERT_IMP(a_push_room, fifo_push, !fifo_stat.full)
  `IRMA_ASSERT_IMP(a_pop_data, fifo_pop, !fifo_stat.empty)
  `IRMA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

@@ sim/tb_ir_range_moving_average.sv @@
// Self-checking testbench for the IR range moving average with distance conversion.
`timescale 1ns / 100ps

module tb_ir_range_moving_average;
  import irma_pkg::*;

  localparam int WIN_LEN       = 25;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTED   = 100;
  localparam int SMP_MAX       = (1 << SMP_W) - 1;

  // Indexes outside the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNMAPPED  = {CFG_IDX_W{1'b1}};

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [DIST_W-1:0] distance;
  } range_word_t;

  // Window predictor and queue of expected output words
  class range_scoreboard;
    logic [SMP_W-1:0]  low_lim;
    logic [SMP_W-1:0]  high_lim;
    logic [NUM_W-1:0]  numer;
    logic [SMP_W-1:0]  offs;
    logic [SMP_W-1:0]  window [WIN_LEN];
    logic [15:0]       sum;
    range_word_t       pending_words[$];
    int                errors;

    function void reset_state();
      low_lim  = LOW_LIMIT_RST;
      high_lim = HIGH_LIMIT_RST;
      numer    = DIST_NUM_RST;
      offs     = SENSOR_OFFS_RST;
      for (int i = 0; i < WIN_LEN; i++) window[i] = SMP_W'(1);
      sum    = 16'(WIN_LEN);
      errors = 0;
      pending_words.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOW_LIMIT:   low_lim  = data[SMP_W-1:0];
        REG_HIGH_LIMIT:  high_lim = data[SMP_W-1:0];
        REG_DIST_NUM:    numer    = data[NUM_W-1:0];
        REG_SENSOR_OFFS: offs     = data[SMP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Shift the sample in, form the mean, and queue a word if it passes
    function void note_sample(logic [SMP_W-1:0] s);
      logic [15:0]       mean_full;
      logic [SMP_W-1:0]  mean;
      logic [QDVD_W-1:0] quot;
      range_word_t       w;
      sum = sum - 16'(window[0]) + 16'(s);
      for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i+1];
      window[WIN_LEN-1] = s;
      mean_full = sum / 16'(WIN_LEN);
      mean = mean_full[SMP_W-1:0];
      if (mean < low_lim || mean > high_lim || mean <= offs) return;
      quot = {numer, {FRAC_W{1'b0}}} / QDVD_W'(mean - offs);
      w.mean     = mean;
      w.distance = (quot > QDVD_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
      pending_words.push_back(w);
    endfunction

    // Compare one output word with the oldest expectation
    task check_word(logic [MEAN_W-1:0] m, logic [DIST_W-1:0] d);
      range_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word mean_value=%0d distance_q8=%0d", m, d));
        return;
      end
      w = pending_words.pop_front();
      if (m !== w.mean)
        report($sformatf("mean_value got %0d want %0d", m, w.mean));
      if (d !== w.distance)
        report($sformatf("distance_q8 got %0d want %0d (mean %0d)", d, w.distance, w.mean));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SMP_W-1:0]      sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [MEAN_W-1:0]     mean_value;
  logic [DIST_W-1:0]     distance_q8;

  range_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_count;

  ir_range_moving_average #(
    .WINDOW_LEN(WIN_LEN)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_value (mean_value),
    .distance_q8(distance_q8)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note accepted samples and check accepted output words
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_sample(sample);
    if (!rst && out_valid && out_ready) sb.check_word(mean_value, distance_q8);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drive out_ready: random stalls, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SEND) ? 72 : (mode == IDLE_BOTH) ? 33 : 0;
    stall_pct     = (mode == IDLE_RECV) ? 72 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  // Offer one sample word and hold it until accepted
  task automatic send_sample(logic [SMP_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Drain, let suppressed samples finish, then the block is idle
  task automatic wait_idle();
    in_valid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Write all registers and one unmapped index; upper bits of the narrow ones carry junk
  task automatic apply_config(int lo, int hi, int num, int offs);
    logic [CFG_DATA_W-SMP_W-1:0] junk;
    wait_idle();
    junk = ($urandom_range(1) == 1) ? '1 : (CFG_DATA_W-SMP_W)'($urandom);
    write_reg(REG_LOW_LIMIT, {junk, SMP_W'(lo)});
    write_reg(REG_HIGH_LIMIT, {~junk, SMP_W'(hi)});
    write_reg(REG_DIST_NUM, CFG_DATA_W'(num));
    write_reg(REG_SENSOR_OFFS, {junk, SMP_W'(offs)});
    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)),
              CFG_DATA_W'($urandom));
    cfg_we = 1'b0;
  endtask

  // Steer the window mean toward a limit, the offset, or somewhere random
  function automatic int pick_target();
    int t;
    case ($urandom_range(7))
      0: t = sb.low_lim;
      1: t = int'(sb.low_lim) - 1;
      2: t = sb.high_lim;
      3: t = int'(sb.high_lim) + 1;
      4: t = sb.offs;
      5: t = int'(sb.offs) + 1;
      default: t = $urandom_range(SMP_MAX);
    endcase
    if (t < 0) t = 0;
    if (t > SMP_MAX) t = SMP_MAX;
    return t;
  endfunction

  function automatic logic [SMP_W-1:0] next_sample(int target);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 20)      v = target;
    else if (pick < 75) v = target + $urandom_range(8) - 4;
    else if (pick < 90) v = $urandom_range(SMP_MAX);
    else                v = ($urandom_range(1) == 1) ? SMP_MAX : 0;
    if (v < 0) v = 0;
    if (v > SMP_MAX) v = SMP_MAX;
    return SMP_W'(v);
  endfunction

  // Runs of samples around moving targets, with optional pressure events
  task automatic run_random(int n, idle_mode_t mode, bit hold_off, bit pause_mid);
    int target;
    int run_left;
    set_idling(mode);
    run_left = 0;
    target   = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        target   = pick_target();
        run_left = $urandom_range(15, 60);
      end
      run_left--;
      if (hold_off && i == n / 4) hold_left = HOLD_CYCLES;
      if (pause_mid && i == n / 2) begin
        in_valid = 1'b0;
        wait_drained();
      end
      send_sample(next_sample(target));
    end
  endtask

  initial begin
    int lo;
    int hi;
    sb = new();
    sb.reset_state();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    sample        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    cycle_count   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: mean climbs from below the low limit past the high limit
    set_idling(IDLE_NONE);
    send_sample('0);
    repeat (18) send_sample(SMP_W'(SMP_MAX));

    // Widest limits, zero offset, largest numerator
    apply_config(0, SMP_MAX, 65535, 0);
    repeat (3) send_sample(SMP_W'(SMP_MAX));
    repeat (3) send_sample('0);

    // Random phases over several settings
    apply_config(LOW_LIMIT_RST, HIGH_LIMIT_RST, DIST_NUM_RST, SENSOR_OFFS_RST);
    run_random(180, IDLE_NONE, 1'b0, 1'b0);
    apply_config(0, SMP_MAX, 65535, 0);
    run_random(180, IDLE_SEND, 1'b0, 1'b0);
    apply_config(SMP_MAX, SMP_MAX, 1, SMP_MAX - 1);
    run_random(200, IDLE_RECV, 1'b0, 1'b0);
    // Crossed limits: nothing passes
    apply_config(300, 200, $urandom_range(65535), 10);
    run_random(60, IDLE_BOTH, 1'b0, 1'b0);
    // Zero numerator, with a long receiver hold-off
    apply_config(0, SMP_MAX, 0, 5);
    run_random(180, IDLE_NONE, 1'b1, 1'b0);
    lo = $urandom_range(500);
    hi = $urandom_range(lo, SMP_MAX);
    apply_config(lo, hi, $urandom_range(65535), $urandom_range(lo + 50));
    run_random(200, IDLE_SEND, 1'b0, 1'b0);
    // Offset at its top: nothing passes
    apply_config(50, 900, 65535, SMP_MAX);
    run_random(60, IDLE_RECV, 1'b0, 1'b0);
    apply_config(20, 600, $urandom_range(65535), 200);
    run_random(180, IDLE_BOTH, 1'b0, 1'b1);
    lo = $urandom_range(300);
    hi = $urandom_range(lo, SMP_MAX);
    apply_config(lo, hi, $urandom_range(1, 65535), $urandom_range(lo));
    run_random(180, IDLE_NONE, 1'b1, 1'b1);

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
